>>> rtl/gmep_pkg.sv
// Shared types, constants and helper functions of the guitar multi-effect processor.
// No dependencies; imported by guitar_multi_effect_processor.
package gmep_pkg;

    // one-hot sequencer states
    typedef enum logic [8:0] {
        ST_CLEAR   = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_READ    = 9'b000000100,
        ST_MODIFY  = 9'b000001000,
        ST_COLLECT = 9'b000010000,
        ST_TFIX    = 9'b000100000,
        ST_VMUL    = 9'b001000000,
        ST_VDIV    = 9'b010000000,
        ST_OUT     = 9'b100000000
    } state_t;

    // effect selection codes
    typedef enum logic [2:0] {
        FX_BYPASS    = 3'd0,
        FX_OVERDRIVE = 3'd1,
        FX_DELAY     = 3'd2,
        FX_ECHO      = 3'd3,
        FX_REVERB    = 3'd4,
        FX_OCTAVE    = 3'd5,
        FX_TREMOLO   = 3'd6
    } effect_t;

    // register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_VOLUME = 2'd1;
    localparam logic [1:0] REG_PARAM  = 2'd2;
    localparam logic [1:0] REG_DRIVE  = 2'd3;

    localparam int X_W   = 14;
    localparam int LEN_W = 21;

    localparam logic [6:0]  KNOB_MAX     = 7'd100;
    localparam logic [7:0]  DRIVE_RESET  = 8'd60;
    localparam logic [11:0] OD_CENTER    = 12'd1768;
    localparam logic [11:0] OD_LOW       = 12'd1760;
    localparam logic [LEN_W-1:0] DLY_STEP = LEN_W'(1500);
    localparam logic [LEN_W-1:0] DLY_MIN  = LEN_W'(500);
    localparam logic [LEN_W-1:0] RVB_MUL [3] = '{LEN_W'(300), LEN_W'(150), LEN_W'(75)};
    localparam logic [3:0]  PITCH_FAST   = 4'd5;
    localparam logic [3:0]  PITCH_OFS    = 4'd4;
    localparam logic [2:0]  PITCH_SLOW   = 3'd6;
    localparam logic [4:0]  TREM_BASE    = 5'd21;
    localparam logic [9:0]  TREM_ENTRIES = 10'd999;
    localparam logic [14:0] TREM_RECIP   = 15'd22369;
    localparam int          TREM_SHIFT   = 28;
    localparam logic [13:0] TREM_DIVISOR = 14'd12000;
    localparam logic [6:0]  VOL_BASE     = 7'd90;
    localparam logic [20:0] VOL_RECIP    = 21'd1342178;
    localparam int          VOL_SHIFT    = 27;
    localparam int          PWM_LOW_W    = 6;

    // knob values above full scale act as full scale
    function automatic logic [6:0] sat_knob(input logic [6:0] k);
        return (k > KNOB_MAX) ? KNOB_MAX : k;
    endfunction

    // k/10 for k up to 100 by reciprocal multiply
    function automatic logic [3:0] div10(input logic [6:0] k);
        logic [17:0] p;
        p = 18'(k) * 18'd205;
        return p[14:11];
    endfunction

    // tremolo sine table
    localparam logic [11:0] SINE_ROM [999] = '{
12'h800,12'h80c,12'h819,12'h826,12'h833,12'h840,12'h84d,12'h85a,12'h866,12'h873,12'h880,12'h88d,
12'h89a,12'h8a7,12'h8b3,12'h8c0,12'h8cd,12'h8da,12'h8e7,12'h8f3,12'h900,12'h90d,12'h91a,12'h926,
12'h933,12'h940,12'h94c,12'h959,12'h966,12'h973,12'h97f,12'h98c,12'h998,12'h9a5,12'h9b2,12'h9be,
12'h9cb,12'h9d7,12'h9e4,12'h9f0,12'h9fd,12'ha09,12'ha16,12'ha22,12'ha2e,12'ha3b,12'ha47,12'ha53,
12'ha60,12'ha6c,12'ha78,12'ha84,12'ha91,12'ha9d,12'haa9,12'hab5,12'hac1,12'hacd,12'had9,12'hae5,
12'haf1,12'hafd,12'hb09,12'hb15,12'hb21,12'hb2d,12'hb38,12'hb44,12'hb50,12'hb5c,12'hb67,12'hb73,
12'hb7e,12'hb8a,12'hb96,12'hba1,12'hbac,12'hbb8,12'hbc3,12'hbcf,12'hbda,12'hbe5,12'hbf0,12'hbfc,
12'hc07,12'hc12,12'hc1d,12'hc28,12'hc33,12'hc3e,12'hc49,12'hc53,12'hc5e,12'hc69,12'hc74,12'hc7e,
12'hc89,12'hc94,12'hc9e,12'hca9,12'hcb3,12'hcbd,12'hcc8,12'hcd2,12'hcdc,12'hce6,12'hcf1,12'hcfb,
12'hd05,12'hd0f,12'hd19,12'hd23,12'hd2c,12'hd36,12'hd40,12'hd4a,12'hd53,12'hd5d,12'hd66,12'hd70,
12'hd79,12'hd82,12'hd8c,12'hd95,12'hd9e,12'hda7,12'hdb0,12'hdb9,12'hdc2,12'hdcb,12'hdd4,12'hddd,
12'hde6,12'hdee,12'hdf7,12'hdff,12'he08,12'he10,12'he19,12'he21,12'he29,12'he31,12'he39,12'he41,
12'he49,12'he51,12'he59,12'he61,12'he69,12'he70,12'he78,12'he7f,12'he87,12'he8e,12'he96,12'he9d,
12'hea4,12'heab,12'heb2,12'heb9,12'hec0,12'hec7,12'hece,12'hed5,12'hedb,12'hee2,12'hee8,12'heef,
12'hef5,12'hefc,12'hf02,12'hf08,12'hf0e,12'hf14,12'hf1a,12'hf20,12'hf26,12'hf2b,12'hf31,12'hf37,
12'hf3c,12'hf42,12'hf47,12'hf4c,12'hf51,12'hf57,12'hf5c,12'hf61,12'hf66,12'hf6a,12'hf6f,12'hf74,
12'hf79,12'hf7d,12'hf82,12'hf86,12'hf8a,12'hf8f,12'hf93,12'hf97,12'hf9b,12'hf9f,12'hfa3,12'hfa6,
12'hfaa,12'hfae,12'hfb1,12'hfb5,12'hfb8,12'hfbb,12'hfbf,12'hfc2,12'hfc5,12'hfc8,12'hfcb,12'hfce,
12'hfd0,12'hfd3,12'hfd6,12'hfd8,12'hfdb,12'hfdd,12'hfdf,12'hfe2,12'hfe4,12'hfe6,12'hfe8,12'hfea,
12'hfeb,12'hfed,12'hfef,12'hff0,12'hff2,12'hff3,12'hff5,12'hff6,12'hff7,12'hff8,12'hff9,12'hffa,
12'hffb,12'hffc,12'hffc,12'hffd,12'hffe,12'hffe,12'hffe,12'hfff,12'hfff,12'hfff,12'hfff,12'hfff,
12'hfff,12'hfff,12'hffe,12'hffe,12'hffe,12'hffd,12'hffc,12'hffc,12'hffb,12'hffa,12'hff9,12'hff8,
12'hff7,12'hff6,12'hff5,12'hff3,12'hff2,12'hff0,12'hfef,12'hfed,12'hfeb,12'hfea,12'hfe8,12'hfe6,
12'hfe4,12'hfe2,12'hfdf,12'hfdd,12'hfdb,12'hfd8,12'hfd6,12'hfd3,12'hfd0,12'hfce,12'hfcb,12'hfc8,
12'hfc5,12'hfc2,12'hfbf,12'hfbb,12'hfb8,12'hfb5,12'hfb1,12'hfae,12'hfaa,12'hfa6,12'hfa3,12'hf9f,
12'hf9b,12'hf97,12'hf93,12'hf8f,12'hf8a,12'hf86,12'hf82,12'hf7d,12'hf79,12'hf74,12'hf6f,12'hf6a,
12'hf66,12'hf61,12'hf5c,12'hf57,12'hf51,12'hf4c,12'hf47,12'hf42,12'hf3c,12'hf37,12'hf31,12'hf2b,
12'hf26,12'hf20,12'hf1a,12'hf14,12'hf0e,12'hf08,12'hf02,12'hefc,12'hef5,12'heef,12'hee8,12'hee2,
12'hedb,12'hed5,12'hece,12'hec7,12'hec0,12'heb9,12'heb2,12'heab,12'hea4,12'he9d,12'he96,12'he8e,
12'he87,12'he7f,12'he78,12'he70,12'he69,12'he61,12'he59,12'he51,12'he49,12'he41,12'he39,12'he31,
12'he29,12'he21,12'he19,12'he10,12'he08,12'hdff,12'hdf7,12'hdee,12'hde6,12'hddd,12'hdd4,12'hdcb,
12'hdc2,12'hdb9,12'hdb0,12'hda7,12'hd9e,12'hd95,12'hd8c,12'hd82,12'hd79,12'hd70,12'hd66,12'hd5d,
12'hd53,12'hd4a,12'hd40,12'hd36,12'hd2c,12'hd23,12'hd19,12'hd0f,12'hd05,12'hcfb,12'hcf1,12'hce6,
12'hcdc,12'hcd2,12'hcc8,12'hcbd,12'hcb3,12'hca9,12'hc9e,12'hc94,12'hc89,12'hc7e,12'hc74,12'hc69,
12'hc5e,12'hc53,12'hc49,12'hc3e,12'hc33,12'hc28,12'hc1d,12'hc12,12'hc07,12'hbfc,12'hbf0,12'hbe5,
12'hbda,12'hbcf,12'hbc3,12'hbb8,12'hbac,12'hba1,12'hb96,12'hb8a,12'hb7e,12'hb73,12'hb67,12'hb5c,
12'hb50,12'hb44,12'hb38,12'hb2d,12'hb21,12'hb15,12'hb09,12'hafd,12'haf1,12'hae5,12'had9,12'hacd,
12'hac1,12'hab5,12'haa9,12'ha9d,12'ha91,12'ha84,12'ha78,12'ha6c,12'ha60,12'ha53,12'ha47,12'ha3b,
12'ha2e,12'ha22,12'ha16,12'ha09,12'h9fd,12'h9f0,12'h9e4,12'h9d7,12'h9cb,12'h9be,12'h9b2,12'h9a5,
12'h998,12'h98c,12'h97f,12'h973,12'h966,12'h959,12'h94c,12'h940,12'h933,12'h926,12'h91a,12'h90d,
12'h900,12'h8f3,12'h8e7,12'h8da,12'h8cd,12'h8c0,12'h8b3,12'h8a7,12'h89a,12'h88d,12'h880,12'h873,
12'h866,12'h85a,12'h84d,12'h840,12'h833,12'h826,12'h819,12'h80c,12'h800,12'h7f3,12'h7e6,12'h7d9,
12'h7cc,12'h7bf,12'h7b2,12'h7a5,12'h799,12'h78c,12'h77f,12'h772,12'h765,12'h758,12'h74c,12'h73f,
12'h732,12'h725,12'h718,12'h70c,12'h6ff,12'h6f2,12'h6e5,12'h6d9,12'h6cc,12'h6bf,12'h6b3,12'h6a6,
12'h699,12'h68c,12'h680,12'h673,12'h667,12'h65a,12'h64d,12'h641,12'h634,12'h628,12'h61b,12'h60f,
12'h602,12'h5f6,12'h5e9,12'h5dd,12'h5d1,12'h5c4,12'h5b8,12'h5ac,12'h59f,12'h593,12'h587,12'h57b,
12'h56e,12'h562,12'h556,12'h54a,12'h53e,12'h532,12'h526,12'h51a,12'h50e,12'h502,12'h4f6,12'h4ea,
12'h4de,12'h4d2,12'h4c7,12'h4bb,12'h4af,12'h4a3,12'h498,12'h48c,12'h481,12'h475,12'h469,12'h45e,
12'h453,12'h447,12'h43c,12'h430,12'h425,12'h41a,12'h40f,12'h403,12'h3f8,12'h3ed,12'h3e2,12'h3d7,
12'h3cc,12'h3c1,12'h3b6,12'h3ac,12'h3a1,12'h396,12'h38b,12'h381,12'h376,12'h36b,12'h361,12'h356,
12'h34c,12'h342,12'h337,12'h32d,12'h323,12'h319,12'h30e,12'h304,12'h2fa,12'h2f0,12'h2e6,12'h2dc,
12'h2d3,12'h2c9,12'h2bf,12'h2b5,12'h2ac,12'h2a2,12'h299,12'h28f,12'h286,12'h27d,12'h273,12'h26a,
12'h261,12'h258,12'h24f,12'h246,12'h23d,12'h234,12'h22b,12'h222,12'h219,12'h211,12'h208,12'h200,
12'h1f7,12'h1ef,12'h1e6,12'h1de,12'h1d6,12'h1ce,12'h1c6,12'h1be,12'h1b6,12'h1ae,12'h1a6,12'h19e,
12'h196,12'h18f,12'h187,12'h180,12'h178,12'h171,12'h169,12'h162,12'h15b,12'h154,12'h14d,12'h146,
12'h13f,12'h138,12'h131,12'h12a,12'h124,12'h11d,12'h117,12'h110,12'h10a,12'h103,12'h0fd,12'h0f7,
12'h0f1,12'h0eb,12'h0e5,12'h0df,12'h0d9,12'h0d4,12'h0ce,12'h0c8,12'h0c3,12'h0bd,12'h0b8,12'h0b3,
12'h0ae,12'h0a8,12'h0a3,12'h09e,12'h099,12'h095,12'h090,12'h08b,12'h086,12'h082,12'h07d,12'h079,
12'h075,12'h070,12'h06c,12'h068,12'h064,12'h060,12'h05c,12'h059,12'h055,12'h051,12'h04e,12'h04a,
12'h047,12'h044,12'h040,12'h03d,12'h03a,12'h037,12'h034,12'h031,12'h02f,12'h02c,12'h029,12'h027,
12'h024,12'h022,12'h020,12'h01d,12'h01b,12'h019,12'h017,12'h015,12'h014,12'h012,12'h010,12'h00f,
12'h00d,12'h00c,12'h00a,12'h009,12'h008,12'h007,12'h006,12'h005,12'h004,12'h003,12'h003,12'h002,
12'h001,12'h001,12'h001,12'h000,12'h000,12'h000,12'h000,12'h000,12'h000,12'h000,12'h001,12'h001,
12'h001,12'h002,12'h003,12'h003,12'h004,12'h005,12'h006,12'h007,12'h008,12'h009,12'h00a,12'h00c,
12'h00d,12'h00f,12'h010,12'h012,12'h014,12'h015,12'h017,12'h019,12'h01b,12'h01d,12'h020,12'h022,
12'h024,12'h027,12'h029,12'h02c,12'h02f,12'h031,12'h034,12'h037,12'h03a,12'h03d,12'h040,12'h044,
12'h047,12'h04a,12'h04e,12'h051,12'h055,12'h059,12'h05c,12'h060,12'h064,12'h068,12'h06c,12'h070,
12'h075,12'h079,12'h07d,12'h082,12'h086,12'h08b,12'h090,12'h095,12'h099,12'h09e,12'h0a3,12'h0a8,
12'h0ae,12'h0b3,12'h0b8,12'h0bd,12'h0c3,12'h0c8,12'h0ce,12'h0d4,12'h0d9,12'h0df,12'h0e5,12'h0eb,
12'h0f1,12'h0f7,12'h0fd,12'h103,12'h10a,12'h110,12'h117,12'h11d,12'h124,12'h12a,12'h131,12'h138,
12'h13f,12'h146,12'h14d,12'h154,12'h15b,12'h162,12'h169,12'h171,12'h178,12'h180,12'h187,12'h18f,
12'h196,12'h19e,12'h1a6,12'h1ae,12'h1b6,12'h1be,12'h1c6,12'h1ce,12'h1d6,12'h1de,12'h1e6,12'h1ef,
12'h1f7,12'h200,12'h208,12'h211,12'h219,12'h222,12'h22b,12'h234,12'h23d,12'h246,12'h24f,12'h258,
12'h261,12'h26a,12'h273,12'h27d,12'h286,12'h28f,12'h299,12'h2a2,12'h2ac,12'h2b5,12'h2bf,12'h2c9,
12'h2d3,12'h2dc,12'h2e6,12'h2f0,12'h2fa,12'h304,12'h30e,12'h319,12'h323,12'h32d,12'h337,12'h342,
12'h34c,12'h356,12'h361,12'h36b,12'h376,12'h381,12'h38b,12'h396,12'h3a1,12'h3ac,12'h3b6,12'h3c1,
12'h3cc,12'h3d7,12'h3e2,12'h3ed,12'h3f8,12'h403,12'h40f,12'h41a,12'h425,12'h430,12'h43c,12'h447,
12'h453,12'h45e,12'h469,12'h475,12'h481,12'h48c,12'h498,12'h4a3,12'h4af,12'h4bb,12'h4c7,12'h4d2,
12'h4de,12'h4ea,12'h4f6,12'h502,12'h50e,12'h51a,12'h526,12'h532,12'h53e,12'h54a,12'h556,12'h562,
12'h56e,12'h57b,12'h587,12'h593,12'h59f,12'h5ac,12'h5b8,12'h5c4,12'h5d1,12'h5dd,12'h5e9,12'h5f6,
12'h602,12'h60f,12'h61b,12'h628,12'h634,12'h641,12'h64d,12'h65a,12'h667,12'h673,12'h680,12'h68c,
12'h699,12'h6a6,12'h6b3,12'h6bf,12'h6cc,12'h6d9,12'h6e5,12'h6f2,12'h6ff,12'h70c,12'h718,12'h725,
12'h732,12'h73f,12'h74c,12'h758,12'h765,12'h772,12'h77f,12'h78c,12'h799,12'h7a5,12'h7b2,12'h7bf,
12'h7cc,12'h7d9,12'h7e6};

endpackage

>>> rtl/gmep_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies; instantiated for every sample line of the effect processor.
module gmep_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/guitar_multi_effect_processor.sv
// Guitar multi-effect processor top level: sequencer, effect datapath, APB registers.
// Depends on gmep_pkg and gmep_ram.
//
// After reset the block runs a clearing pass over all sample lines, one entry per cycle,
// covering max(DELAY_LEN, REVERB_LEN, PITCH_LEN) entries (262144 at the default sizes); no
// request is taken during it, while register writes are. Then each request runs from
// acceptance to the next ready through one line read, a read-modify-write of the line entry
// with a read of the next entry, and four multiply steps for the tremolo divide by 12000
// and the volume scaling. The line memories each have one read and one write port, which
// sets the read, modify and collect steps. The result waits in an output register, so the
// next request is accepted as soon as it is loaded.
module guitar_multi_effect_processor
    import gmep_pkg::*;
#(
    parameter int DELAY_LEN  = 262144,
    parameter int REVERB_LEN = 32768,
    parameter int PITCH_LEN  = 10000
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample request
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] adc_sample,
    // result
    output logic        out_valid,
    input  logic        out_ready,
    output logic [13:0] out_sample,
    output logic [5:0]  pwm_low,
    output logic [7:0]  pwm_high
);

    localparam int DW = $clog2(DELAY_LEN);
    localparam int RW = $clog2(REVERB_LEN);
    localparam int PW = $clog2(PITCH_LEN);
    localparam int CLR_LEN = (DELAY_LEN > REVERB_LEN) ?
        ((DELAY_LEN > PITCH_LEN) ? DELAY_LEN : PITCH_LEN) :
        ((REVERB_LEN > PITCH_LEN) ? REVERB_LEN : PITCH_LEN);
    localparam int CW = $clog2(CLR_LEN + 1);

    state_t           state_reg;
    logic [CW-1:0]    clr_cnt_reg;
    logic [2:0]       mode_reg;
    logic [6:0]       volume_reg;
    logic [6:0]       param_reg;
    logic [7:0]       drive_reg;

    logic [DW-1:0]    dly_ptr_reg;
    logic [DW-1:0]    echo_ptr_reg;
    logic [RW-1:0]    rvb_ptr_reg [3];
    logic [PW-1:0]    pw_ptr_reg;
    logic [PW-1:0]    pr_ptr_reg;
    logic [2:0]       prate_reg;
    logic [4:0]       tdiv_reg;
    logic [9:0]       tidx_reg;
    logic             out_valid_reg;

    logic [X_W-1:0]   x_reg;
    logic [X_W-1:0]   y_reg;
    logic [11:0]      sine_reg;
    logic             echo_fwd_reg;
    logic [X_W-1:0]   echo_fwd_val_reg;
    logic             rvb_fwd_reg [3];
    logic [X_W-1:0]   rvb_fwd_val_reg [3];
    logic [25:0]      tprod_reg;
    logic [12:0]      tq_reg;
    logic [20:0]      vprod_reg;
    logic [13:0]      res_reg;
    logic [13:0]      out_sample_reg;

    // memory ports
    logic             dly_we, echo_we, pit_we;
    logic [DW-1:0]    dly_waddr, dly_raddr, echo_waddr, echo_raddr;
    logic [X_W-1:0]   dly_wdata, echo_wdata, pit_wdata;
    logic [X_W-1:0]   dly_rdata, echo_rdata, pit_rdata;
    logic [PW-1:0]    pit_waddr, pit_raddr;
    logic             rvb_we [3];
    logic [RW-1:0]    rvb_waddr [3];
    logic [RW-1:0]    rvb_raddr [3];
    logic [X_W-1:0]   rvb_wdata [3];
    logic [X_W-1:0]   rvb_rdata [3];

    // derived knob values and pointer steps
    logic [6:0]       knob;
    logic [3:0]       knob10;
    logic [6:0]       gain;
    logic [LEN_W-1:0] long_len;
    logic [LEN_W-1:0] dly_inc, echo_inc;
    logic [DW-1:0]    dly_nxt, echo_nxt;
    logic [LEN_W-1:0] rvb_len [3];
    logic [LEN_W-1:0] rvb_inc [3];
    logic [RW-1:0]    rvb_nxt [3];
    logic [X_W-1:0]   echo_avg;
    logic [X_W-1:0]   rvb_avg [3];
    logic [X_W-1:0]   rvb_sel [3];
    logic [X_W-1:0]   echo_sel;
    logic             cfg_wr;

    assign knob   = sat_knob(param_reg);
    assign knob10 = div10(knob);
    assign gain   = VOL_BASE + 7'(div10(sat_knob(volume_reg)));
    assign cfg_wr = psel && penable && pwrite;

    // delay and echo line length, cut to the store depth
    always_comb
    begin
        long_len = (knob == 7'd0) ? DLY_MIN : LEN_W'(knob) * DLY_STEP;
        if (long_len > LEN_W'(DELAY_LEN))
        begin
            long_len = LEN_W'(DELAY_LEN);
        end
        dly_inc  = LEN_W'(dly_ptr_reg) + LEN_W'(1);
        echo_inc = LEN_W'(echo_ptr_reg) + LEN_W'(1);
        dly_nxt  = (dly_inc >= long_len) ? '0 : dly_inc[DW-1:0];
        echo_nxt = (echo_inc >= long_len) ? '0 : echo_inc[DW-1:0];
        echo_avg = X_W'((15'(x_reg) + 15'(echo_rdata)) >> 1);
        echo_sel = echo_fwd_reg ? echo_fwd_val_reg : echo_rdata;
    end

    // reverb lane lengths and next pointers
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rvb_len[i] = LEN_W'(knob) * RVB_MUL[i];
            if (rvb_len[i] > LEN_W'(REVERB_LEN))
            begin
                rvb_len[i] = LEN_W'(REVERB_LEN);
            end
            rvb_inc[i] = LEN_W'(rvb_ptr_reg[i]) + LEN_W'(1);
            rvb_nxt[i] = (rvb_inc[i] >= rvb_len[i]) ? '0 : rvb_inc[i][RW-1:0];
            rvb_avg[i] = X_W'((15'(x_reg) + 15'(rvb_rdata[i])) >> 1);
            rvb_sel[i] = rvb_fwd_reg[i] ? rvb_fwd_val_reg[i] : rvb_rdata[i];
        end
    end

    // memory port control
    always_comb
    begin
        dly_we     = 1'b0;
        dly_waddr  = dly_ptr_reg;
        dly_wdata  = x_reg;
        dly_raddr  = dly_nxt;
        echo_we    = 1'b0;
        echo_waddr = echo_ptr_reg;
        echo_wdata = echo_avg;
        echo_raddr = echo_ptr_reg;
        pit_we     = 1'b0;
        pit_waddr  = pw_ptr_reg;
        pit_wdata  = x_reg;
        pit_raddr  = pr_ptr_reg;
        for (int i = 0; i < 3; i++)
        begin
            rvb_we[i]    = 1'b0;
            rvb_waddr[i] = rvb_ptr_reg[i];
            rvb_wdata[i] = rvb_avg[i];
            rvb_raddr[i] = rvb_ptr_reg[i];
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                dly_we     = clr_cnt_reg < CW'(DELAY_LEN);
                dly_waddr  = clr_cnt_reg[DW-1:0];
                dly_wdata  = '0;
                echo_we    = clr_cnt_reg < CW'(DELAY_LEN);
                echo_waddr = clr_cnt_reg[DW-1:0];
                echo_wdata = '0;
                pit_we     = clr_cnt_reg < CW'(PITCH_LEN);
                pit_waddr  = clr_cnt_reg[PW-1:0];
                pit_wdata  = '0;
                for (int i = 0; i < 3; i++)
                begin
                    rvb_we[i]    = clr_cnt_reg < CW'(REVERB_LEN);
                    rvb_waddr[i] = clr_cnt_reg[RW-1:0];
                    rvb_wdata[i] = '0;
                end
            end
            ST_READ:
            begin
                dly_we = (mode_reg == FX_DELAY);
                pit_we = (mode_reg == FX_OCTAVE);
            end
            ST_MODIFY:
            begin
                echo_we    = (mode_reg == FX_ECHO);
                echo_raddr = echo_nxt;
                for (int i = 0; i < 3; i++)
                begin
                    rvb_we[i]    = (mode_reg == FX_REVERB);
                    rvb_raddr[i] = rvb_nxt[i];
                end
            end
            default:
            begin
            end
        endcase
    end

    // sample lines
    gmep_ram #(.WIDTH(X_W), .DEPTH(DELAY_LEN)) u_delay_ram (
        .clk(clk), .we(dly_we), .waddr(dly_waddr), .wdata(dly_wdata),
        .raddr(dly_raddr), .rdata(dly_rdata)
    );

    gmep_ram #(.WIDTH(X_W), .DEPTH(DELAY_LEN)) u_echo_ram (
        .clk(clk), .we(echo_we), .waddr(echo_waddr), .wdata(echo_wdata),
        .raddr(echo_raddr), .rdata(echo_rdata)
    );

    gmep_ram #(.WIDTH(X_W), .DEPTH(PITCH_LEN)) u_pitch_ram (
        .clk(clk), .we(pit_we), .waddr(pit_waddr), .wdata(pit_wdata),
        .raddr(pit_raddr), .rdata(pit_rdata)
    );

    for (genvar g = 0; g < 3; g++)
    begin : g_rvb
        gmep_ram #(.WIDTH(X_W), .DEPTH(REVERB_LEN)) u_reverb_ram (
            .clk(clk), .we(rvb_we[g]), .waddr(rvb_waddr[g]), .wdata(rvb_wdata[g]),
            .raddr(rvb_raddr[g]), .rdata(rvb_rdata[g])
        );
    end

    // octave read pointer step and tremolo index step
    logic [PW:0]  pr_sum;
    logic [2:0]   prate_next;
    logic [PW-1:0] pr_ptr_next;
    logic [PW:0]  pw_inc;
    logic [4:0]   tdiv_inc;
    logic [4:0]   tdiv_next;
    logic [9:0]   tidx_inc;
    logic [9:0]   tidx_next;

    always_comb
    begin
        prate_next = prate_reg;
        if (knob10 >= PITCH_FAST)
        begin
            pr_sum = (PW+1)'(pr_ptr_reg) + (PW+1)'(knob10 - PITCH_OFS);
        end
        else
        begin
            prate_next = prate_reg + 3'd1;
            pr_sum     = (PW+1)'(pr_ptr_reg);
            if (prate_next >= PITCH_SLOW - 3'(knob10))
            begin
                prate_next = '0;
                pr_sum     = (PW+1)'(pr_ptr_reg) + (PW+1)'(1);
            end
        end
        pr_ptr_next = (pr_sum >= (PW+1)'(PITCH_LEN)) ? '0 : pr_sum[PW-1:0];
        pw_inc      = (PW+1)'(pw_ptr_reg) + (PW+1)'(1);

        tdiv_inc  = tdiv_reg + 5'd1;
        tdiv_next = tdiv_inc;
        tidx_inc  = tidx_reg;
        if (tdiv_inc >= TREM_BASE + 5'(knob10))
        begin
            tdiv_next = '0;
            tidx_inc  = tidx_reg + 10'd1;
        end
        tidx_next = (tidx_inc >= TREM_ENTRIES) ? 10'd1 : tidx_inc;
    end

    // sequencer, registers, pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            mode_reg      <= FX_BYPASS;
            volume_reg    <= '0;
            param_reg     <= '0;
            drive_reg     <= DRIVE_RESET;
            dly_ptr_reg   <= '0;
            echo_ptr_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                rvb_ptr_reg[i] <= '0;
            end
            pw_ptr_reg    <= '0;
            pr_ptr_reg    <= '0;
            prate_reg     <= '0;
            tdiv_reg      <= '0;
            tidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    REG_MODE:   mode_reg   <= pwdata[2:0];
                    REG_VOLUME: volume_reg <= pwdata[6:0];
                    REG_PARAM:  param_reg  <= pwdata[6:0];
                    REG_DRIVE:  drive_reg  <= pwdata[7:0];
                    default:    mode_reg   <= mode_reg;
                endcase
            end

            // result taken while no new one is loaded
            if (out_valid_reg && out_ready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + CW'(1);
                    if (clr_cnt_reg == CW'(CLR_LEN - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    if (mode_reg == FX_TREMOLO)
                    begin
                        tdiv_reg <= tdiv_next;
                        tidx_reg <= tidx_next;
                    end
                    state_reg <= ST_MODIFY;
                end
                ST_MODIFY:
                begin
                    case (mode_reg)
                        FX_DELAY:  dly_ptr_reg  <= dly_nxt;
                        FX_ECHO:   echo_ptr_reg <= echo_nxt;
                        FX_REVERB:
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                rvb_ptr_reg[i] <= rvb_nxt[i];
                            end
                        end
                        FX_OCTAVE:
                        begin
                            pw_ptr_reg <= (pw_inc >= (PW+1)'(PITCH_LEN)) ? '0 : pw_inc[PW-1:0];
                            pr_ptr_reg <= pr_ptr_next;
                            prate_reg  <= prate_next;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_reg <= ST_COLLECT;
                end
                ST_COLLECT: state_reg <= ST_TFIX;
                ST_TFIX:    state_reg <= ST_VMUL;
                ST_VMUL:    state_reg <= ST_VDIV;
                ST_VDIV:    state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:    state_reg <= ST_CLEAR;
            endcase
        end
    end

    // effect datapath
    logic [11:0] od_w;
    logic [13:0] od_hi, od_lo;
    logic [9:0]  od_3d;
    logic [40:0] tq_full;
    logic [25:0] trem_rem;
    logic [41:0] vol_full;

    always_comb
    begin
        od_w     = 12'(drive_reg) + 12'(KNOB_MAX) - 12'(knob);
        od_hi    = 14'(OD_CENTER) + 14'(od_w);
        od_lo    = 14'(OD_LOW) - 14'(od_w);
        od_3d    = 10'(drive_reg) * 10'd3;
        tq_full  = 41'(tprod_reg) * 41'(TREM_RECIP);
        trem_rem = tprod_reg - 26'(tq_reg) * 26'(TREM_DIVISOR);
        vol_full = 42'(vprod_reg) * 42'(VOL_RECIP);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                x_reg <= {adc_sample, 2'b00};
            end
            ST_READ:
            begin
                sine_reg <= SINE_ROM[tidx_next];
            end
            ST_MODIFY:
            begin
                echo_fwd_reg     <= (echo_nxt == echo_ptr_reg);
                echo_fwd_val_reg <= echo_avg;
                for (int i = 0; i < 3; i++)
                begin
                    rvb_fwd_reg[i]     <= (rvb_nxt[i] == rvb_ptr_reg[i]);
                    rvb_fwd_val_reg[i] <= rvb_avg[i];
                end
                tprod_reg   <= 26'(x_reg) * 26'(sine_reg);
                case (mode_reg)
                    FX_OVERDRIVE:
                    begin
                        if (x_reg > od_hi)
                        begin
                            y_reg <= 14'(OD_CENTER) + 14'(od_3d);
                        end
                        else if (x_reg < od_lo)
                        begin
                            y_reg <= 14'(OD_CENTER) - 14'(od_3d);
                        end
                        else
                        begin
                            y_reg <= x_reg;
                        end
                    end
                    FX_DELAY:
                    begin
                        y_reg <= X_W'((15'(x_reg) + 15'(dly_rdata)) >> 1);
                    end
                    FX_OCTAVE:
                    begin
                        y_reg <= (pr_ptr_reg == pw_ptr_reg) ? x_reg : pit_rdata;
                    end
                    FX_ECHO, FX_REVERB, FX_TREMOLO:
                    begin
                        y_reg <= y_reg;
                    end
                    default:
                    begin
                        y_reg <= x_reg;
                    end
                endcase
            end
            ST_COLLECT:
            begin
                tq_reg <= tq_full[TREM_SHIFT +: 13];
                case (mode_reg)
                    FX_ECHO:
                    begin
                        y_reg <= X_W'((15'(x_reg) + 15'(echo_sel)) >> 1);
                    end
                    FX_REVERB:
                    begin
                        y_reg <= X_W'((16'(x_reg) + 16'(rvb_sel[0]) + 16'(rvb_sel[1])
                                      + 16'(rvb_sel[2])) >> 2);
                    end
                    default:
                    begin
                        y_reg <= y_reg;
                    end
                endcase
            end
            ST_TFIX:
            begin
                if (mode_reg == FX_TREMOLO)
                begin
                    y_reg <= (trem_rem >= 26'(TREM_DIVISOR)) ? 14'(tq_reg) + 14'd1
                                                              : 14'(tq_reg);
                end
            end
            ST_VMUL:
            begin
                vprod_reg <= 21'(y_reg) * 21'(gain);
            end
            ST_VDIV:
            begin
                res_reg <= vol_full[VOL_SHIFT +: 14];
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_sample_reg <= res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // register read back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODE:   prdata = 32'(mode_reg);
            REG_VOLUME: prdata = 32'(volume_reg);
            REG_PARAM:  prdata = 32'(param_reg);
            REG_DRIVE:  prdata = 32'(drive_reg);
            default:    prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign pwm_low    = out_sample_reg[PWM_LOW_W-1:0];
    assign pwm_high   = out_sample_reg[13:PWM_LOW_W];

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for guitar_multi_effect_processor: directed table, then random phases.
// Depends on gmep_pkg and the processor RTL; carries its own bit-exact model of the effects.
module tb_top;
    import gmep_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DLY_DEPTH   = 262144;
    localparam int RVB_DEPTH   = 32768;
    localparam int LOOP_DEPTH  = 10000;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 24;
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    typedef struct packed {
        logic [13:0] smp;
        logic [5:0]  lo;
        logic [7:0]  hi;
    } audio_out_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [6:0]  vol;
        logic [6:0]  prm;
        logic [7:0]  drv;
        logic [11:0] smp;
        logic        chk;
        logic [13:0] want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_ready;
    logic [11:0] adc_sample;
    logic        out_valid, out_ready;
    logic [13:0] out_sample;
    logic [5:0]  pwm_low;
    logic [7:0]  pwm_high;

    // model copy of registers and effect state
    logic [2:0]  cur_mode;
    logic [6:0]  cur_vol, cur_prm;
    logic [7:0]  cur_drv;
    logic [13:0] dly_mem [DLY_DEPTH];
    logic [13:0] echo_mem [DLY_DEPTH];
    logic [13:0] rvb_mem [3][RVB_DEPTH];
    logic [13:0] loop_mem [LOOP_DEPTH];
    int          dly_ptr, echo_ptr, loop_wr, loop_rd, loop_div, trem_cnt, trem_pos;
    int          rvb_ptr [3];

    audio_out_t  pending_out [$];
    int          mismatches;
    int          cycles;

    dir_row_t dir_rows [22] = '{
        '{FX_BYPASS,    7'd0,   7'd0,   8'd60,  12'd0,    1'b1, 14'd0},
        '{FX_BYPASS,    7'd0,   7'd0,   8'd60,  12'd4095, 1'b1, 14'd14742},
        '{FX_BYPASS,    7'd100, 7'd0,   8'd60,  12'd4095, 1'b1, 14'd16380},
        '{FX_BYPASS,    7'd127, 7'd0,   8'd60,  12'd4095, 1'b1, 14'd16380},
        '{MODE_UNUSED,  7'd100, 7'd0,   8'd60,  12'd1234, 1'b1, 14'd4936},
        '{FX_OVERDRIVE, 7'd100, 7'd0,   8'd60,  12'd4095, 1'b1, 14'd1948},
        '{FX_OVERDRIVE, 7'd100, 7'd0,   8'd60,  12'd0,    1'b1, 14'd1588},
        '{FX_OVERDRIVE, 7'd100, 7'd0,   8'd60,  12'd442,  1'b1, 14'd1768},
        '{FX_OVERDRIVE, 7'd100, 7'd127, 8'd255, 12'd0,    1'b1, 14'd1003},
        '{FX_OVERDRIVE, 7'd100, 7'd127, 8'd255, 12'd4095, 1'b1, 14'd2533},
        '{FX_OVERDRIVE, 7'd100, 7'd100, 8'd0,   12'd441,  1'b1, 14'd1764},
        '{FX_DELAY,     7'd100, 7'd0,   8'd60,  12'd4095, 1'b1, 14'd8190},
        '{FX_DELAY,     7'd55,  7'd0,   8'd60,  12'd2048, 1'b0, 14'd0},
        '{FX_ECHO,      7'd100, 7'd0,   8'd60,  12'd4095, 1'b1, 14'd8190},
        '{FX_ECHO,      7'd100, 7'd3,   8'd60,  12'd1000, 1'b0, 14'd0},
        '{FX_REVERB,    7'd100, 7'd1,   8'd60,  12'd4095, 1'b0, 14'd0},
        '{FX_REVERB,    7'd100, 7'd0,   8'd60,  12'd4095, 1'b0, 14'd0},
        '{FX_REVERB,    7'd100, 7'd127, 8'd60,  12'd17,   1'b0, 14'd0},
        '{FX_OCTAVE,    7'd100, 7'd100, 8'd60,  12'd4095, 1'b0, 14'd0},
        '{FX_OCTAVE,    7'd100, 7'd0,   8'd60,  12'd3000, 1'b0, 14'd0},
        '{FX_TREMOLO,   7'd100, 7'd0,   8'd60,  12'd4095, 1'b0, 14'd0},
        '{FX_TREMOLO,   7'd90,  7'd127, 8'd60,  12'd0,    1'b0, 14'd0}
    };

    guitar_multi_effect_processor dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .adc_sample (adc_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sample (out_sample),
        .pwm_low    (pwm_low),
        .pwm_high   (pwm_high)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // knob values above full scale act as full scale
    function int knob_sat(input logic [6:0] k);
        return (k > 7'd100) ? 100 : int'(k);
    endfunction

    // clear model state to its reset values
    function void clear_effects();
        cur_mode = FX_BYPASS;
        cur_vol  = '0;
        cur_prm  = '0;
        cur_drv  = 8'd60;
        for (int i = 0; i < DLY_DEPTH; i++)
        begin
            dly_mem[i]  = '0;
            echo_mem[i] = '0;
        end
        for (int i = 0; i < RVB_DEPTH; i++)
            for (int j = 0; j < 3; j++) rvb_mem[j][i] = '0;
        for (int i = 0; i < LOOP_DEPTH; i++) loop_mem[i] = '0;
        dly_ptr = 0; echo_ptr = 0; loop_wr = 0; loop_rd = 0; loop_div = 0;
        trem_cnt = 0; trem_pos = 0;
        for (int j = 0; j < 3; j++) rvb_ptr[j] = 0;
    endfunction

    // one sample through the effect chain, updating effect state
    function audio_out_t process_sample(input logic [11:0] s);
        int x, k, y, len, w, v, sum, res;
        int rvb_mul [3];
        audio_out_t r;
        x = int'(s) * 4;
        k = knob_sat(cur_prm);
        y = x;
        rvb_mul = '{300, 150, 75};
        case (cur_mode)
            FX_OVERDRIVE:
            begin
                w = int'(cur_drv) + 100 - k;
                if (x > 1768 + w) y = 1768 + 3 * int'(cur_drv);
                else if (x < 1760 - w) y = 1768 - 3 * int'(cur_drv);
            end
            FX_DELAY:
            begin
                len = (k == 0) ? 500 : k * 1500;
                if (len > DLY_DEPTH) len = DLY_DEPTH;
                if (dly_ptr >= DLY_DEPTH) dly_ptr = 0;
                dly_mem[dly_ptr] = 14'(x);
                dly_ptr++;
                if (dly_ptr >= len) dly_ptr = 0;
                y = (int'(dly_mem[dly_ptr]) + x) >> 1;
            end
            FX_ECHO:
            begin
                len = (k == 0) ? 500 : k * 1500;
                if (len > DLY_DEPTH) len = DLY_DEPTH;
                if (echo_ptr >= DLY_DEPTH) echo_ptr = 0;
                echo_mem[echo_ptr] = 14'((x + int'(echo_mem[echo_ptr])) >> 1);
                echo_ptr++;
                if (echo_ptr >= len) echo_ptr = 0;
                y = (int'(echo_mem[echo_ptr]) + x) >> 1;
            end
            FX_REVERB:
            begin
                sum = x;
                for (int j = 0; j < 3; j++)
                begin
                    len = k * rvb_mul[j];
                    if (len > RVB_DEPTH) len = RVB_DEPTH;
                    if (rvb_ptr[j] >= RVB_DEPTH) rvb_ptr[j] = 0;
                    rvb_mem[j][rvb_ptr[j]] = 14'((x + int'(rvb_mem[j][rvb_ptr[j]])) >> 1);
                    rvb_ptr[j]++;
                    if (rvb_ptr[j] >= len) rvb_ptr[j] = 0;
                    sum += int'(rvb_mem[j][rvb_ptr[j]]);
                end
                y = sum >> 2;
            end
            FX_OCTAVE:
            begin
                if (loop_wr >= LOOP_DEPTH) loop_wr = 0;
                loop_mem[loop_wr] = 14'(x);
                loop_wr++;
                if (loop_wr >= LOOP_DEPTH) loop_wr = 0;
                if (loop_rd >= LOOP_DEPTH) loop_rd = 0;
                y = int'(loop_mem[loop_rd]);
                v = k / 10;
                if (v >= 5) loop_rd += v - 4;
                else
                begin
                    loop_div++;
                    if (loop_div >= 6 - v)
                    begin
                        loop_div = 0;
                        loop_rd++;
                    end
                end
                if (loop_rd >= LOOP_DEPTH) loop_rd = 0;
            end
            FX_TREMOLO:
            begin
                trem_cnt++;
                if (trem_cnt >= 21 + k / 10)
                begin
                    trem_cnt = 0;
                    trem_pos++;
                end
                if (trem_pos >= 999) trem_pos = 1;
                y = (x * int'(SINE_ROM[trem_pos])) / 12000;
            end
            default: y = x;
        endcase
        res = (y * (90 + knob_sat(cur_vol) / 10) / 100) & 16'h3FFF;
        r.smp = 14'(res);
        r.lo  = r.smp[5:0];
        r.hi  = r.smp[13:6];
        return r;
    endfunction

    // random gap length: mostly none or short, a few long
    function int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // apb register write: setup then access
    task reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MODE:   cur_mode = val[2:0];
            REG_VOLUME: cur_vol  = val[6:0];
            REG_PARAM:  cur_prm  = val[6:0];
            REG_DRIVE:  cur_drv  = val[7:0];
            default: ;
        endcase
    endtask

    // wait for all outstanding results, then let the pipeline settle
    task drain_results();
        in_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task load_settings(input logic [2:0] m, input logic [6:0] vl, input logic [6:0] pk,
                       input logic [7:0] dr);
        drain_results();
        reg_write(REG_MODE, 32'(m));
        reg_write(REG_VOLUME, 32'(vl));
        reg_write(REG_PARAM, 32'(pk));
        reg_write(REG_DRIVE, 32'(dr));
    endtask

    // send one sample request; the expectation is queued at acceptance
    task send_sample(input logic [11:0] s, input logic chk, input logic [13:0] want);
        audio_out_t e;
        int n;
        in_valid   <= 1'b1;
        adc_sample <= s;
        do @(posedge clk); while (!in_ready);
        e = process_sample(s);
        if (chk)
        begin
            e.smp = want;
            e.lo  = want[5:0];
            e.hi  = want[13:6];
        end
        pending_out.push_back(e);
        n = pick_gap();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // main stimulus
    initial
    begin
        logic [2:0] m;
        logic [6:0] vl, pk;
        logic [7:0] dr;
        int p;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; adc_sample = '0;
        mismatches = 0;
        clear_effects();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[i])
        begin
            if (i == 0 || dir_rows[i].mode != cur_mode || dir_rows[i].vol != cur_vol ||
                dir_rows[i].prm != cur_prm || dir_rows[i].drv != cur_drv)
                load_settings(dir_rows[i].mode, dir_rows[i].vol, dir_rows[i].prm,
                              dir_rows[i].drv);
            send_sample(dir_rows[i].smp, dir_rows[i].chk, dir_rows[i].want);
        end

        // random phases
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 0)
            begin
                m = FX_TREMOLO; vl = 7'd127; pk = 7'd127; dr = 8'd255;
            end
            else if (ph == 1)
            begin
                m = FX_BYPASS; vl = 7'd0; pk = 7'd0; dr = 8'd0;
            end
            else
            begin
                m  = 3'(ph % 8);
                vl = 7'($urandom_range(0, 127));
                dr = 8'($urandom_range(0, 255));
                p  = $urandom_range(0, 3);
                pk = (p == 0) ? 7'd0 : (p == 1) ? 7'($urandom_range(1, 5))
                                                : 7'($urandom_range(0, 127));
            end
            load_settings(m, vl, pk, dr);
            for (int n = 0; n < 80; n++)
                send_sample(12'($urandom_range(0, 4095)), 1'b0, '0);
        end

        drain_results();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // result side stalls
    initial
    begin
        int n;
        out_ready = 1'b0;
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 9) == 0 ? 150 : $urandom_range(1, 20)) @(posedge clk);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        audio_out_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_out.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result out_sample=%0d", out_sample);
            end
            else
            begin
                e = pending_out.pop_front();
                if (out_sample !== e.smp || pwm_low !== e.lo || pwm_high !== e.hi)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 e.smp, e.lo, e.hi, out_sample, pwm_low, pwm_high);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial cycles = 0;

endmodule

>>> sim.f
rtl/gmep_pkg.sv
rtl/gmep_ram.sv
rtl/guitar_multi_effect_processor.sv
tb/tb_top.sv
